// ===== design/http_get_request_line_parser_defines.svh =====
// ----------------------------------------------------------------------------
// http get request line parser assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef HTTP_GET_REQUEST_LINE_PARSER_DEFINES_SVH
`define HTTP_GET_REQUEST_LINE_PARSER_DEFINES_SVH

// same-cycle implication
`define HGLP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HGLP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/hglp_pkg.sv =====
// ----------------------------------------------------------------------------
// hglp_pkg
// types, codes and match text for the http get request line parser
// ----------------------------------------------------------------------------
package hglp_pkg;

  localparam int unsigned URL_MAX   = 256;
  localparam int unsigned URL_CNT_W = $clog2(URL_MAX + 1);

  localparam logic [URL_CNT_W-1:0] URL_FULL = URL_CNT_W'(URL_MAX);
  localparam logic [URL_CNT_W-1:0] URL_LAST = URL_CNT_W'(URL_MAX - 1);

  // parser phases
  localparam logic [2:0] PH_METHOD   = 3'd0;
  localparam logic [2:0] PH_URL      = 3'd1;
  localparam logic [2:0] PH_PROTO    = 3'd2;
  localparam logic [2:0] PH_BADLINE  = 3'd3;
  localparam logic [2:0] PH_HEADERS  = 3'd4;
  localparam logic [2:0] PH_HDR_LONG = 3'd5;

  // verdict codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_BAD    = 3'd1;
  localparam logic [2:0] ST_NOREQ  = 3'd2;
  localparam logic [2:0] ST_CLOSED = 3'd3;
  localparam logic [2:0] ST_LONG   = 3'd4;

  // result kinds
  localparam logic KIND_URL     = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // input actions
  localparam logic ACT_DATA  = 1'b0;
  localparam logic ACT_CLOSE = 1'b1;

  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_DOT  = 8'h2e;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_ONE  = 8'h31;

  localparam logic [3:0] METHOD_LEN = 4'd3;
  localparam logic [3:0] PROTO_LEN  = 4'd8;
  localparam logic [3:0] MINOR_POS  = 4'd7;
  localparam logic [3:0] POS_MAX    = 4'd15;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] url_byte;
    logic [2:0] status;
    logic       version;
  } res_t;

  // "GET"
  function automatic logic [7:0] method_char(input logic [1:0] pos);
    logic [7:0] c;
    case (pos)
      2'd0:    c = 8'h47;
      2'd1:    c = 8'h45;
      2'd2:    c = 8'h54;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "HTTP/1."
  function automatic logic [7:0] proto_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h48;
      3'd1:    c = 8'h54;
      3'd2:    c = 8'h54;
      3'd3:    c = 8'h50;
      3'd4:    c = 8'h2f;
      3'd5:    c = 8'h31;
      3'd6:    c = 8'h2e;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== design/http_get_request_line_parser.sv =====
// ----------------------------------------------------------------------------
// http_get_request_line_parser
// Parses an HTTP request one byte per item. The request line must be a GET
// with protocol HTTP/1.0 or HTTP/1.1; URL bytes stream out as tentative
// results led by '.', header lines are skipped, and an empty line, a bad
// line or a close gives the verdict. One item is taken every cycle while
// the output is not held; a result passes through the input register and
// then the result register. The parser's state update for each item sets
// that rate. No pass is needed after reset.
// ----------------------------------------------------------------------------
module http_get_request_line_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       action_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       kind_o,
  output logic [7:0] url_byte_o,
  output logic [2:0] status_o,
  output logic       version_o
);
  import hglp_pkg::*;

  item_t in_item;
  item_t s1_item;
  logic  s1_valid;
  logic  out_can_take;
  logic  fire;
  logic  res_valid;
  res_t  res;
  res_t  out_res;

  assign in_item.action    = action_i;
  assign in_item.data_byte = data_byte_i;

  assign fire = s1_valid && out_can_take;

  hglp_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item),
    .take_i     (fire),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  hglp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .item_i      (s1_item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  hglp_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res),
    .can_take_o  (out_can_take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  assign kind_o     = out_res.kind;
  assign url_byte_o = out_res.url_byte;
  assign status_o   = out_res.status;
  assign version_o  = out_res.version;

endmodule

// ===== design/hglp_in_stage.sv =====
// ----------------------------------------------------------------------------
// hglp_in_stage
// input register, holds one item until the parser takes it
// ----------------------------------------------------------------------------
module hglp_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  hglp_pkg::item_t in_item_i,
  input  logic            take_i,
  output logic            valid_o,
  output hglp_pkg::item_t item_o
);
  import hglp_pkg::*;

  logic  valid_q, valid_d;
  logic  accept;
  item_t item_q;

  assign in_stall_o = valid_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== design/hglp_parse.sv =====
// ----------------------------------------------------------------------------
// hglp_parse
// request line state and single-pass byte step
// ----------------------------------------------------------------------------
`include "http_get_request_line_parser_defines.svh"

module hglp_parse (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  hglp_pkg::item_t item_i,
  output logic            res_valid_o,
  output hglp_pkg::res_t  res_o
);
  import hglp_pkg::*;

  logic [2:0]           phase_q, phase_d;
  logic [3:0]           pos_q, pos_d;
  logic                 mism_q, mism_d;
  logic [URL_CNT_W-1:0] url_cnt_q, url_cnt_d;
  logic                 ver_q, ver_d;
  logic                 line_q, line_d;
  logic                 res_valid;
  res_t                 res;
  logic [7:0]           b;
  logic                 verdict;
  logic [2:0]           vstat;
  logic                 vver;
  logic                 url_emit;
  logic [7:0]           url_val;
  logic [3:0]           pos_bump;

  assign b        = item_i.data_byte;
  assign pos_bump = (pos_q < POS_MAX) ? pos_q + 4'd1 : pos_q;

  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    mism_d    = mism_q;
    url_cnt_d = url_cnt_q;
    ver_d     = ver_q;
    line_d    = line_q;
    verdict   = 1'b0;
    vstat     = ST_OK;
    vver      = 1'b0;
    url_emit  = 1'b0;
    url_val   = b;

    if (item_i.action == ACT_CLOSE) begin
      verdict = 1'b1;
      vstat   = ST_CLOSED;
    end else if (b == CH_CR) begin
      // ignored everywhere
    end else if (b == CH_LF) begin
      case (phase_q)
        PH_METHOD: begin
          verdict = 1'b1;
          vstat   = line_q ? ST_BAD : ST_NOREQ;
        end
        PH_PROTO: begin
          if (!mism_q && pos_q == PROTO_LEN) begin
            phase_d = (url_cnt_q == URL_FULL) ? PH_HDR_LONG : PH_HEADERS;
            pos_d   = '0;
            mism_d  = 1'b0;
            line_d  = 1'b0;
          end else begin
            verdict = 1'b1;
            vstat   = ST_BAD;
          end
        end
        PH_HEADERS, PH_HDR_LONG: begin
          if (!line_q) begin
            verdict = 1'b1;
            if (phase_q == PH_HDR_LONG) begin
              vstat = ST_LONG;
            end else begin
              vstat = ST_OK;
              vver  = ver_q;
            end
          end else begin
            line_d = 1'b0;
          end
        end
        default: begin
          verdict = 1'b1;
          vstat   = ST_BAD;
        end
      endcase
    end else begin
      line_d = 1'b1;
      case (phase_q)
        PH_METHOD: begin
          if (b == CH_SP) begin
            if (mism_q || pos_q != METHOD_LEN) begin
              phase_d = PH_BADLINE;
            end else begin
              phase_d  = PH_URL;
              pos_d    = '0;
              mism_d   = 1'b0;
              url_emit = 1'b1;
              url_val  = CH_DOT;
            end
          end else begin
            if (pos_q >= METHOD_LEN || method_char(pos_q[1:0]) != b) begin
              mism_d = 1'b1;
            end
            pos_d = pos_bump;
          end
        end
        PH_URL: begin
          if (b == CH_SP) begin
            phase_d = PH_PROTO;
            pos_d   = '0;
            mism_d  = 1'b0;
          end else begin
            url_emit = 1'b1;
          end
        end
        PH_PROTO: begin
          if (pos_q < MINOR_POS) begin
            if (proto_char(pos_q[2:0]) != b) begin
              mism_d = 1'b1;
            end
          end else if (pos_q == MINOR_POS) begin
            if (b == CH_ZERO) begin
              ver_d = 1'b0;
            end else if (b == CH_ONE) begin
              ver_d = 1'b1;
            end else begin
              mism_d = 1'b1;
            end
          end else begin
            mism_d = 1'b1;
          end
          pos_d = pos_bump;
        end
        default: begin
        end
      endcase
    end

    res_valid = 1'b0;
    res       = '0;
    if (verdict) begin
      phase_d     = PH_METHOD;
      pos_d       = '0;
      mism_d      = 1'b0;
      url_cnt_d   = '0;
      ver_d       = 1'b0;
      line_d      = 1'b0;
      res_valid   = 1'b1;
      res.kind    = KIND_VERDICT;
      res.status  = vstat;
      res.version = vver;
    end else if (url_emit) begin
      if (url_cnt_q >= URL_LAST) begin
        url_cnt_d = URL_FULL;
      end else begin
        url_cnt_d    = url_cnt_q + URL_CNT_W'(1);
        res_valid    = 1'b1;
        res.kind     = KIND_URL;
        res.url_byte = url_val;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_METHOD;
      pos_q     <= '0;
      mism_q    <= 1'b0;
      url_cnt_q <= '0;
      ver_q     <= 1'b0;
      line_q    <= 1'b0;
    end else if (fire_i) begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      mism_q    <= mism_d;
      url_cnt_q <= url_cnt_d;
      ver_q     <= ver_d;
      line_q    <= line_d;
    end
  end

  assign res_valid_o = fire_i && res_valid;
  assign res_o       = res;

  `HGLP_ASSERT_IMP(a_url_cnt_bound, 1'b1, url_cnt_q <= URL_FULL, "url count past limit")
  `HGLP_ASSERT_IMP(a_url_from_line, res_valid_o && res.kind == KIND_URL,
    phase_q == PH_METHOD || phase_q == PH_URL, "url byte outside request line")
  `HGLP_ASSERT_NXT(a_verdict_clears, res_valid_o && res.kind == KIND_VERDICT,
    phase_q == PH_METHOD && url_cnt_q == '0 && !line_q, "state not cleared after verdict")
  `HGLP_ASSERT_IMP(a_url_below_max, res_valid_o && res.kind == KIND_URL,
    url_cnt_q < URL_LAST, "url byte emitted at full store")

endmodule

// ===== design/hglp_out_stage.sv =====
// ----------------------------------------------------------------------------
// hglp_out_stage
// result register toward the downstream side
// ----------------------------------------------------------------------------
module hglp_out_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  hglp_pkg::res_t res_i,
  output logic           can_take_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output hglp_pkg::res_t res_o
);
  import hglp_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  assign can_take_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q && out_stall_i;
    if (load_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule
